// ===== rtl/core/mnemonic_mix_counter_assert.svh =====
// Assertion macros for the mnemonic mix counter.
`ifndef MNEMONIC_MIX_COUNTER_ASSERT_SVH
`define MNEMONIC_MIX_COUNTER_ASSERT_SVH
`ifndef SYNTH
`define MMC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MMC_ASSERT_IMPLY(label, ante, cons, msg)
`define MMC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/mmc_pkg.sv =====
package mmc_pkg;

  localparam int NUM_CLASSES = 9;
  localparam int CLASS_W     = 4;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 8;
  localparam int WIN_W       = 32;
  localparam int HIST_W      = 24;
  localparam int COST_W      = 5;
  localparam int CNT_OUT_W   = 32;
  localparam int TOT_I_W     = 36;
  localparam int TOT_C_W     = 38;

  localparam logic [CLASS_W-1:0] FIRST_CLASS = 4'd0;
  localparam logic [CLASS_W-1:0] PUSH_CLASS  = 4'd6;
  localparam logic [CLASS_W-1:0] LAST_CLASS  = 4'd8;

  localparam logic [BYTE_W-1:0] BYTE_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_NL  = 8'h0A;

  localparam logic [WIN_W-1:0] PATTERN [NUM_CLASSES] = '{
    32'h0061_6464, 32'h0073_7562, 32'h006D_756C, 32'h0064_6976, 32'h006D_6F76,
    32'h006C_6561, 32'h7075_7368, 32'h0070_6F70, 32'h0072_6573
  };

  localparam logic [COST_W-1:0] COST [NUM_CLASSES] = '{
    5'd1, 5'd1, 5'd3, 5'd24, 5'd1, 5'd3, 5'd1, 5'd1, 5'd1
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_SUM,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [CLASS_W-1:0] idx;
  } close_t;

  typedef struct packed {
    logic               sel_seq;
    logic               acc_clr;
    logic               acc_en;
    logic               cnt_clr;
    logic [CLASS_W-1:0] idx;
  } tally_ctrl_t;

endpackage

// ===== rtl/core/mmc_seg.sv =====
module mmc_seg import mmc_pkg::*; #(
  parameter int SEGMENT_BYTES = 99
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_en_i,
  input  logic              eot_en_i,
  input  logic [BYTE_W-1:0] byte_i,
  output close_t            close_o
);

  logic [HIST_W-1:0]      recent_q, recent_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic                   zero_q, zero_d;
  logic [NUM_CLASSES-1:0] flags_q, flags_d;
  close_t                 close_q, close_d;

  logic [WIN_W-1:0]       win;
  logic [NUM_CLASSES-1:0] hit;
  logic [NUM_CLASSES-1:0] flags_byte;
  logic [NUM_CLASSES-1:0] flags_sel;
  logic [LEN_W-1:0]       len_inc;
  logic                   active;
  logic                   byte_close;
  logic                   close_req;
  logic [CLASS_W-1:0]     first_idx;

  always_comb begin
    win     = {recent_q, byte_i};
    active  = !zero_q && (byte_i != BYTE_NUL);
    len_inc = len_q + LEN_W'(1);
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (CLASS_W'(i) == PUSH_CLASS) begin
        hit[i] = (win == PATTERN[i]);
      end else begin
        hit[i] = (win[HIST_W-1:0] == PATTERN[i][HIST_W-1:0]);
      end
    end
    flags_byte = flags_q | (active ? hit : '0);
    byte_close = (byte_i == BYTE_NL) || (len_inc >= LEN_W'(SEGMENT_BYTES));
  end

  always_comb begin
    flags_sel = byte_en_i ? flags_byte : flags_q;
    close_req = (byte_en_i && byte_close) || (eot_en_i && (len_q != '0));
    first_idx = FIRST_CLASS;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (flags_sel[i]) begin
        first_idx = CLASS_W'(i);
      end
    end
    close_d.valid = close_req && (|flags_sel);
    close_d.idx   = first_idx;
  end

  always_comb begin
    recent_d = recent_q;
    len_d    = len_q;
    zero_d   = zero_q;
    flags_d  = flags_q;
    if (close_req) begin
      recent_d = '0;
      len_d    = '0;
      zero_d   = 1'b0;
      flags_d  = '0;
    end else if (byte_en_i) begin
      len_d = len_inc;
      if (!zero_q) begin
        if (byte_i == BYTE_NUL) begin
          zero_d = 1'b1;
        end else begin
          recent_d = win[HIST_W-1:0];
          flags_d  = flags_byte;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      len_q    <= '0;
      zero_q   <= 1'b0;
      flags_q  <= '0;
      close_q  <= '0;
    end else begin
      recent_q <= recent_d;
      len_q    <= len_d;
      zero_q   <= zero_d;
      flags_q  <= flags_d;
      close_q  <= close_d;
    end
  end

  assign close_o = close_q;

endmodule

// ===== rtl/core/mmc_tally.sv =====
module mmc_tally import mmc_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  close_t               close_i,
  input  tally_ctrl_t          ctrl_i,
  output logic [CNT_OUT_W-1:0] class_count_o,
  output logic [TOT_I_W-1:0]   instr_total_o,
  output logic [TOT_C_W-1:0]   total_cycles_o
);

  localparam int WideW = (COUNT_BITS > TOT_C_W) ? COUNT_BITS : TOT_C_W;

  logic [COUNT_BITS-1:0] cnt_q [NUM_CLASSES];
  logic [TOT_I_W-1:0]    acc_i_q, acc_i_d;
  logic [TOT_C_W-1:0]    acc_c_q, acc_c_d;

  logic [CLASS_W-1:0]    rd_idx;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [COUNT_BITS-1:0] inc_val;
  logic [WideW-1:0]      cnt_wide;
  logic [TOT_C_W-1:0]    prod_c;
  logic                  inc_en;

  always_comb begin
    rd_idx   = ctrl_i.sel_seq ? ctrl_i.idx : close_i.idx;
    cnt_rd   = cnt_q[rd_idx];
    inc_val  = (&cnt_rd) ? cnt_rd : cnt_rd + COUNT_BITS'(1);
    inc_en   = close_i.valid && !ctrl_i.sel_seq;
    cnt_wide = WideW'(cnt_rd);
    prod_c   = cnt_wide[TOT_C_W-1:0] * TOT_C_W'(COST[ctrl_i.idx]);
  end

  always_comb begin
    acc_i_d = acc_i_q;
    acc_c_d = acc_c_q;
    if (ctrl_i.acc_clr) begin
      acc_i_d = '0;
      acc_c_d = '0;
    end else if (ctrl_i.acc_en) begin
      acc_i_d = acc_i_q + cnt_wide[TOT_I_W-1:0];
      acc_c_d = acc_c_q + prod_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (ctrl_i.cnt_clr) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (inc_en) begin
      cnt_q[rd_idx] <= inc_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_i_q <= '0;
      acc_c_q <= '0;
    end else begin
      acc_i_q <= acc_i_d;
      acc_c_q <= acc_c_d;
    end
  end

  assign class_count_o  = cnt_wide[CNT_OUT_W-1:0];
  assign instr_total_o  = acc_i_q;
  assign total_cycles_o = acc_c_q;

endmodule

// ===== rtl/core/mnemonic_mix_counter.sv =====
// Chan Handshake                Payload
// in   in_valid_i/in_ready_o    kind_i, text_byte_i
// out  out_valid_o/out_ready_i  class_index_o, class_count_o, instr_total_o, total_cycles_o, last_o
//
// A text byte can be accepted in every cycle while the input is ready.
// An end-of-text request is followed by a flush step that settles the last segment count,
// summation of all nine classes on the shared accumulator, then nine report items.
// The input is not ready from end of text until the ninth report item is taken.
// Reset clears all counters and segment state; a stalled report item holds its payload.

`include "mnemonic_mix_counter_assert.svh"

module mnemonic_mix_counter import mmc_pkg::*; #(
  parameter int SEGMENT_BYTES = 99,
  parameter int COUNT_BITS    = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [BYTE_W-1:0]    text_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CLASS_W-1:0]   class_index_o,
  output logic [CNT_OUT_W-1:0] class_count_o,
  output logic [TOT_I_W-1:0]   instr_total_o,
  output logic [TOT_C_W-1:0]   total_cycles_o,
  output logic                 last_o
);

  state_e             state_q, state_d;
  logic [CLASS_W-1:0] idx_q, idx_d;
  logic               in_acc;
  logic               byte_en;
  logic               eot_en;
  close_t             seg_close;
  tally_ctrl_t        ctrl;

  assign in_acc  = in_valid_i && in_ready_o;
  assign byte_en = in_acc && !kind_i;
  assign eot_en  = in_acc && kind_i;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (eot_en) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_SUM;
        idx_d   = FIRST_CLASS;
      end
      ST_SUM: begin
        if (idx_q == LAST_CLASS) begin
          state_d = ST_EMIT;
          idx_d   = FIRST_CLASS;
        end else begin
          idx_d = idx_q + CLASS_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (idx_q == LAST_CLASS) begin
            state_d = ST_IDLE;
            idx_d   = FIRST_CLASS;
          end else begin
            idx_d = idx_q + CLASS_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        idx_d   = FIRST_CLASS;
      end
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    out_valid_o  = (state_q == ST_EMIT);
    ctrl.sel_seq = (state_q inside {ST_SUM, ST_EMIT});
    ctrl.acc_clr = eot_en;
    ctrl.acc_en  = (state_q == ST_SUM);
    ctrl.cnt_clr = (state_q == ST_EMIT) && out_ready_i && (idx_q == LAST_CLASS);
    ctrl.idx     = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= FIRST_CLASS;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  mmc_seg #(
    .SEGMENT_BYTES(SEGMENT_BYTES)
  ) u_seg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_en_i(byte_en),
    .eot_en_i (eot_en),
    .byte_i   (text_byte_i),
    .close_o  (seg_close)
  );

  mmc_tally #(
    .COUNT_BITS(COUNT_BITS)
  ) u_tally (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .close_i       (seg_close),
    .ctrl_i        (ctrl),
    .class_count_o (class_count_o),
    .instr_total_o (instr_total_o),
    .total_cycles_o(total_cycles_o)
  );

  assign class_index_o = idx_q;
  assign last_o        = (idx_q == LAST_CLASS);

  `MMC_ASSERT_IMPLY(a_no_overlap, out_valid_o, !in_ready_o, "Input ready during report.")
  `MMC_ASSERT_IMPLY(a_close_when_counting, seg_close.valid, !ctrl.sel_seq, "Count pending.")
  `MMC_ASSERT_NEXT(a_last_to_idle, out_valid_o && out_ready_i && last_o, state_q == ST_IDLE, "Block not idle after last report.")
  `MMC_ASSERT_NEXT(a_flush_to_sum, state_q == ST_FLUSH, (state_q == ST_SUM) && (idx_q == FIRST_CLASS), "Summation did not start at class zero.")

endmodule
